// File: design/data_run_decode_and_locate_top_defines.svh
// Assertion macros for the run-list decoder
`ifndef DATA_RUN_DECODE_AND_LOCATE_TOP_DEFINES_SVH
`define DATA_RUN_DECODE_AND_LOCATE_TOP_DEFINES_SVH
`ifndef SYNTH
`define DRL_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define DRL_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define DRL_ASSERT_IMP(label, clk, rst_n, a, c)
`define DRL_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// File: design/drl_pkg.sv
// ---------------------------------------------------------------------------
// drl_pkg
// Shared types and constants of the run-list decoder and record locator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package drl_pkg;
    localparam int MAX_RUNS_DEF = 64;
    localparam logic [2:0] ST_DONE_LOADED = 3'd0;
    localparam logic [2:0] ST_DONE_EMPTY  = 3'd1;
    localparam logic [2:0] ST_BAD_HEADER  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW    = 3'd3;
    localparam logic [2:0] ST_LOCATED     = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd5;
    localparam logic [2:0] ST_BAD_GEOM    = 3'd6;
    localparam logic [1:0] CFG_BPS = 2'd0;
    localparam logic [1:0] CFG_SPC = 2'd1;
    localparam logic [1:0] CFG_BPR = 2'd2;
    localparam logic [1:0] CFG_TSC = 2'd3;
    // divider request/response
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;
    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [63:0] rem;
    } div_rsp_t;
endpackage

// File: design/data_run_decode_and_locate_top.sv
// Run bytes: each is taken in S_IDLE; the byte that closes a run then passes
// through S_FIN, and through S_OUT too when the run is stored. Locate: two
// passes of the 64-step radix-2 shared divider, then S_MUL (a linear result),
// then S_RD and S_CHK for each stored run walked through the run table memory.
// One item in flight; tready low while busy. Result held in an output
// register that frees once taken. rst_n asynchronously clears all control
// state and restores configuration defaults; the run tables are not cleared.
// ---------------------------------------------------------------------------
// data_run_decode_and_locate_top
// Run-list decoder and record locator with a shared iterative divider.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "data_run_decode_and_locate_top_defines.svh"
module data_run_decode_and_locate_top
    import drl_pkg::*;
#(
    parameter int MAX_RUNS = MAX_RUNS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: run_byte[7:0], record_number[55:8]
    input  logic [55:0]  s_tdata,
    // tuser: cmd[0], first_byte[1]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[2:0], run_count[9:3], cluster[72:10], offset_in_cluster[93:73]
    output logic [95:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int CW = $clog2(MAX_RUNS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIN   = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_DIVW  = 4'd3;
    localparam logic [3:0] S_DIV2  = 4'd4;
    localparam logic [3:0] S_DIV2W = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_CHK   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_OFFSET = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    // configuration
    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [16:0] bpr_reg;
    logic [47:0] tsc_reg;

    logic [3:0]  state_reg, state_next;
    logic [1:0]  ph_reg, ph_next;
    logic [3:0]  left_reg, left_next;
    logic [3:0]  lnib_reg, lnib_next;
    logic [3:0]  onib_reg, onib_next;
    logic [63:0] lacc_reg, lacc_next;
    logic [63:0] oacc_reg, oacc_next;
    logic [63:0] rc_reg, rc_next;
    logic [CW-1:0] runs_reg, runs_next;
    logic        loaded_reg, loaded_next;
    logic [47:0] rec_reg, rec_next;
    logic [63:0] rpc_reg, rpc_next;
    logic [63:0] tgt_reg, tgt_next;
    logic [63:0] off_reg, off_next;
    logic [63:0] cur_reg, cur_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic        ov_reg, ov_next;
    logic [2:0]  ost_reg, ost_next;
    logic [62:0] ocl_reg, ocl_next;
    logic [20:0] ooff_reg, ooff_next;
    logic        ov_out_reg, ov_out_next;
    logic [CW-1:0] ocnt_reg, ocnt_next;

    div_req_t dreq;
    div_rsp_t drsp;
    logic          we;
    logic [63:0]   ram_start, ram_len;
    logic [20:0]   mprod;

    drl_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    drl_ram #(.WIDTH(64), .DEPTH(MAX_RUNS)) u_start_ram (
        .clk(clk), .we(we), .waddr(runs_reg[AW-1:0]), .wdata(rc_reg),
        .raddr(idx_reg[AW-1:0]), .rdata(ram_start));
    drl_ram #(.WIDTH(64), .DEPTH(MAX_RUNS)) u_len_ram (
        .clk(clk), .we(we), .waddr(runs_reg[AW-1:0]), .wdata(lacc_reg),
        .raddr(idx_reg[AW-1:0]), .rdata(ram_len));

    // a result taken in this cycle frees the output register for the next item
    assign s_tready = (state_reg == S_IDLE) && !(ov_out_reg && !m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid = ov_out_reg;
    assign m_tdata = {2'b0, ooff_reg, ocl_reg, 7'(ocnt_reg), ost_reg};

    // sign-extended offset
    logic [63:0] off_ext;
    logic [63:0] dmask;
    always_comb
    begin
        off_ext = oacc_reg;
        dmask = ~64'd0 << {onib_reg[2:0], 3'b000};
        if (onib_reg != 4'd0 && onib_reg < 4'd8
            && oacc_reg[{onib_reg[2:0], 3'b000} - 6'd1])
        begin
            off_ext = oacc_reg | dmask;
        end
    end

    logic [3:0]  hl, ho;
    logic [2:0]  bidx;
    logic [63:0] bsh;
    logic [63:0] tdiff, csum;
    logic        fresh;
    logic [7:0]  b;

    always_comb
    begin
        state_next = state_reg;
        ph_next = ph_reg; left_next = left_reg;
        lnib_next = lnib_reg; onib_next = onib_reg;
        lacc_next = lacc_reg; oacc_next = oacc_reg;
        rc_next = rc_reg; runs_next = runs_reg; loaded_next = loaded_reg;
        rec_next = rec_reg; rpc_next = rpc_reg; tgt_next = tgt_reg;
        off_next = off_reg; cur_next = cur_reg; idx_next = idx_reg;
        ov_next = ov_reg;
        ost_next = ost_reg; ocl_next = ocl_reg; ooff_next = ooff_reg;
        ocnt_next = ocnt_reg;
        ov_out_next = ov_out_reg && !m_tready;
        dreq.start = 1'b0; dreq.dividend = '0; dreq.divisor = '0;
        we = 1'b0;
        b = s_tdata[7:0];
        hl = b[3:0]; ho = b[7:4];
        bidx = 3'd0;
        bsh = '0;
        tdiff = tgt_reg - cur_reg;
        csum = cur_reg + ram_len;
        fresh = 1'b0;
        mprod = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    if (s_tuser[0])
                    begin
                        rec_next = s_tdata[55:8];
                        state_next = S_DIV;
                    end
                    else
                    begin
                        fresh = s_tuser[1];
                        if (fresh)
                        begin
                            ph_next = PH_HEADER; left_next = '0;
                            lnib_next = '0; onib_next = '0;
                            lacc_next = '0; oacc_next = '0; rc_next = '0;
                            runs_next = '0; loaded_next = 1'b0;
                        end
                        unique case (fresh ? PH_HEADER : ph_reg)
                            PH_HEADER:
                            begin
                                if (b == 8'd0)
                                begin
                                    loaded_next = (runs_next != '0);
                                    ph_next = PH_STOP;
                                    ost_next = loaded_next ? ST_DONE_LOADED
                                                           : ST_DONE_EMPTY;
                                    ocl_next = '0; ooff_next = '0;
                                    ocnt_next = runs_next; ov_out_next = 1'b1;
                                end
                                else
                                begin
                                    lnib_next = hl; onib_next = ho;
                                    if (hl == 4'd0 || hl > 4'd8 || ho > 4'd8)
                                    begin
                                        loaded_next = (runs_next != '0);
                                        ph_next = PH_STOP;
                                        ost_next = ST_BAD_HEADER;
                                        ocl_next = '0; ooff_next = '0;
                                        ocnt_next = runs_next;
                                        ov_out_next = 1'b1;
                                    end
                                    else
                                    begin
                                        lacc_next = '0; oacc_next = '0;
                                        left_next = hl; ph_next = PH_LENGTH;
                                    end
                                end
                            end
                            PH_LENGTH:
                            begin
                                bidx = 3'(lnib_reg - left_reg);
                                bsh = {56'd0, b} << {bidx, 3'b000};
                                lacc_next = lacc_reg | bsh;
                                left_next = left_reg - 4'd1;
                                if (left_reg == 4'd1)
                                begin
                                    if (onib_reg == 4'd0)
                                    begin
                                        state_next = S_FIN;
                                    end
                                    else
                                    begin
                                        left_next = onib_reg;
                                        ph_next = PH_OFFSET;
                                    end
                                end
                            end
                            PH_OFFSET:
                            begin
                                bidx = 3'(onib_reg - left_reg);
                                bsh = {56'd0, b} << {bidx, 3'b000};
                                oacc_next = oacc_reg | bsh;
                                left_next = left_reg - 4'd1;
                                if (left_reg == 4'd1)
                                begin
                                    state_next = S_FIN;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_FIN:
            begin
                ph_next = PH_HEADER;
                rc_next = rc_reg + off_ext;
                state_next = S_IDLE;
                if (off_ext != 64'd0)
                begin
                    if (runs_reg >= CW'(MAX_RUNS))
                    begin
                        loaded_next = 1'b1; ph_next = PH_STOP;
                        ost_next = ST_OVERFLOW; ocl_next = '0; ooff_next = '0;
                        ocnt_next = runs_reg; ov_out_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                // store the run with updated running cluster
                we = 1'b1;
                runs_next = runs_reg + CW'(1);
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                // bytes per cluster = spc * bps, narrow multiply
                dreq.start = 1'b1;
                dreq.dividend = {43'd0, 21'(spc_reg * bps_reg)};
                dreq.divisor = {47'd0, bpr_reg};
                if (bpr_reg == 17'd0 || spc_reg == 8'd0 || bps_reg == 13'd0)
                begin
                    dreq.start = 1'b0;
                    ost_next = ST_BAD_GEOM; ocl_next = '0; ooff_next = '0;
                    ocnt_next = runs_reg; ov_out_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (drsp.done)
                begin
                    rpc_next = drsp.quot;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (rpc_reg == 64'd0)
                begin
                    ost_next = ST_BAD_GEOM; ocl_next = '0; ooff_next = '0;
                    ocnt_next = runs_reg; ov_out_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    dreq.start = 1'b1;
                    dreq.dividend = {16'd0, rec_reg};
                    dreq.divisor = rpc_reg;
                    state_next = S_DIV2W;
                end
            end
            S_DIV2W:
            begin
                if (drsp.done)
                begin
                    tgt_next = drsp.quot;
                    off_next = drsp.rem;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // rem < rpc <= 2^21/bpr, product fits 21 bits
                mprod = 21'(off_reg[20:0] * bpr_reg);
                off_next = {43'd0, mprod};
                cur_next = '0; idx_next = '0; ov_next = 1'b0;
                if (!loaded_reg || runs_reg == '0)
                begin
                    ost_next = ST_LOCATED;
                    ocl_next = 63'({16'd0, tsc_reg} + tgt_reg);
                    ooff_next = mprod; ocnt_next = runs_reg;
                    ov_out_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (!ov_reg && tdiff < ram_len)
                begin
                    ost_next = ST_LOCATED;
                    ocl_next = 63'(ram_start + tdiff);
                    ooff_next = off_reg[20:0]; ocnt_next = runs_reg;
                    ov_out_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    if (!ov_reg)
                    begin
                        if (csum < cur_reg)
                        begin
                            cur_next = ~64'd0;
                        end
                        else
                        begin
                            cur_next = csum;
                        end
                        if (cur_next > tgt_reg)
                        begin
                            ov_next = 1'b1;
                        end
                    end
                    idx_next = idx_reg + CW'(1);
                    if (idx_next >= runs_reg)
                    begin
                        ost_next = ST_NOT_FOUND; ocl_next = '0; ooff_next = '0;
                        ocnt_next = runs_reg; ov_out_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg <= 13'd512; spc_reg <= 8'd8;
            bpr_reg <= 17'd1024; tsc_reg <= '0;
            state_reg <= S_IDLE; ph_reg <= PH_HEADER; left_reg <= '0;
            lnib_reg <= '0; onib_reg <= '0; lacc_reg <= '0; oacc_reg <= '0;
            rc_reg <= '0; runs_reg <= '0; loaded_reg <= 1'b0;
            ov_out_reg <= 1'b0; idx_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_BPS: bps_reg <= cfg_data[12:0];
                    CFG_SPC: spc_reg <= cfg_data[7:0];
                    CFG_BPR: bpr_reg <= cfg_data[16:0];
                    CFG_TSC: tsc_reg <= cfg_data[47:0];
                    default: ;
                endcase
            end
            state_reg <= state_next; ph_reg <= ph_next; left_reg <= left_next;
            lnib_reg <= lnib_next; onib_reg <= onib_next;
            lacc_reg <= lacc_next; oacc_reg <= oacc_next;
            rc_reg <= rc_next; runs_reg <= runs_next; loaded_reg <= loaded_next;
            ov_out_reg <= ov_out_next; idx_reg <= idx_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next; rpc_reg <= rpc_next; tgt_reg <= tgt_next;
        off_reg <= off_next; cur_reg <= cur_next;
        ost_reg <= ost_next; ocl_reg <= ocl_next; ooff_reg <= ooff_next;
        ocnt_reg <= ocnt_next;
    end

    `DRL_ASSERT_IMP(a_runs_max, clk, rst_n, 1'b1, runs_reg <= CW'(MAX_RUNS))
    `DRL_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `DRL_ASSERT_IMP(a_busy_nrdy, clk, rst_n, state_reg != S_IDLE, !s_tready)
endmodule

// File: design/drl_ram.sv
// ---------------------------------------------------------------------------
// drl_ram
// Generic single-port-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module drl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

// File: design/drl_div.sv
// ---------------------------------------------------------------------------
// drl_div
// Restoring radix-2 divider, 64-bit, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module drl_div
    import drl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [63:0] q_reg, q_next;
    logic [64:0] r_reg, r_next;
    logic [63:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    // one shift-subtract step
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[63:0], q_reg[63]} - {1'b0, d_reg};
        if (req.start)
        begin
            q_next = req.dividend;
            r_next = '0;
            d_next = req.divisor;
            cnt_next = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[63:0], q_reg[63]};
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem = r_reg[63:0];
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-list decoder and record locator. A queue
// of items feeds a clocked driver; a clocked monitor compares each result
// with the oldest prediction of an in-bench decoder/locator model. Phases of
// directed and random run lists and locates run under several geometries.
// ---------------------------------------------------------------------------
module tb_top;
    import drl_pkg::*;

    typedef struct {
        bit          cmd;
        bit          first;
        logic [7:0]  rbyte;
        logic [47:0] rec;
    } run_item_t;

    typedef struct {
        logic [2:0]  status;
        logic [6:0]  runs;
        logic [62:0] cl;
        logic [20:0] off;
    } loc_result_t;

    typedef enum logic [1:0] {P_HEADER, P_LENGTH, P_OFFSET, P_STOPPED} parse_ph_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;

    data_run_decode_and_locate_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    run_item_t   pending_q[$];
    loc_result_t expected_q[$];
    run_item_t   cur_item;
    int          errors = 0;
    int          items_added = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;
    bit          quiet = 0;
    int          send_gap = 0;
    int          recv_stall = 0;
    longint      cycles = 0;

    // model configuration
    logic [12:0] m_bps;
    logic [7:0]  m_spc;
    logic [16:0] m_bpr;
    logic [47:0] m_tsc;

    // model parser and run table
    parse_ph_t   ph;
    int          left_cnt;
    int          len_nib;
    int          off_nib;
    logic [63:0] len_acc;
    logic [63:0] off_acc;
    logic [63:0] cur_cluster;
    logic [63:0] start_tab[64];
    logic [63:0] len_tab[64];
    int          run_cnt;
    bit          loaded;

    function automatic loc_result_t mk_result(logic [2:0] st, logic [63:0] c, logic [63:0] o);
        loc_result_t r;
        r.status = st;
        r.runs   = run_cnt[6:0];
        r.cl     = c[62:0];
        r.off    = o[20:0];
        return r;
    endfunction

    function automatic void clear_runs();
        ph = P_HEADER;
        left_cnt = 0;
        len_nib = 0;
        off_nib = 0;
        len_acc = '0;
        off_acc = '0;
        cur_cluster = '0;
        run_cnt = 0;
        loaded = 0;
    endfunction

    // close a run once its offset bytes are in
    function automatic bit close_run(output loc_result_t r);
        logic [63:0] o;
        int top;
        o = off_acc;
        ph = P_HEADER;
        if (off_nib > 0 && off_nib < 8)
        begin
            top = off_nib * 8;
            if (o[top-1])
                o = o | (~64'd0 << top);
        end
        cur_cluster = cur_cluster + o;
        if (o == 0)
            return 0;
        if (run_cnt >= 64)
        begin
            loaded = 1;
            ph = P_STOPPED;
            r = mk_result(ST_OVERFLOW, 0, 0);
            return 1;
        end
        start_tab[run_cnt] = cur_cluster;
        len_tab[run_cnt] = len_acc;
        run_cnt++;
        return 0;
    endfunction

    function automatic bit locate_record(input logic [47:0] rec, output loc_result_t r);
        logic [63:0] bpc, rpc, target, offs, cur;
        logic [64:0] sum;
        bpc = 64'(m_spc) * 64'(m_bps);
        if (m_bpr == 0 || bpc == 0)
        begin
            r = mk_result(ST_BAD_GEOM, 0, 0);
            return 1;
        end
        rpc = bpc / 64'(m_bpr);
        if (rpc == 0)
        begin
            r = mk_result(ST_BAD_GEOM, 0, 0);
            return 1;
        end
        target = 64'(rec) / rpc;
        offs = (64'(rec) % rpc) * 64'(m_bpr);
        if (!loaded || run_cnt == 0)
        begin
            r = mk_result(ST_LOCATED, 64'(m_tsc) + target, offs);
            return 1;
        end
        cur = 0;
        for (int i = 0; i < run_cnt; i++)
        begin
            if (target >= cur && target - cur < len_tab[i])
            begin
                r = mk_result(ST_LOCATED, start_tab[i] + (target - cur), offs);
                return 1;
            end
            sum = 65'(cur) + 65'(len_tab[i]);
            cur = sum[64] ? ~64'd0 : sum[63:0];
        end
        r = mk_result(ST_NOT_FOUND, 0, 0);
        return 1;
    endfunction

    // expected result of one accepted item, if it causes one
    function automatic bit predict_item(input run_item_t it, output loc_result_t r);
        int idx;
        if (it.cmd)
            return locate_record(it.rec, r);
        if (it.first)
            clear_runs();
        case (ph)
            P_HEADER:
            begin
                if (it.rbyte == 0)
                begin
                    loaded = run_cnt > 0;
                    ph = P_STOPPED;
                    r = mk_result(loaded ? ST_DONE_LOADED : ST_DONE_EMPTY, 0, 0);
                    return 1;
                end
                len_nib = it.rbyte[3:0];
                off_nib = it.rbyte[7:4];
                if (len_nib == 0 || len_nib > 8 || off_nib > 8)
                begin
                    loaded = run_cnt > 0;
                    ph = P_STOPPED;
                    r = mk_result(ST_BAD_HEADER, 0, 0);
                    return 1;
                end
                len_acc = '0;
                off_acc = '0;
                left_cnt = len_nib;
                ph = P_LENGTH;
                return 0;
            end
            P_LENGTH:
            begin
                idx = (len_nib - left_cnt) & 7;
                len_acc = len_acc | (64'(it.rbyte) << (idx * 8));
                left_cnt--;
                if (left_cnt == 0)
                begin
                    if (off_nib == 0)
                        return close_run(r);
                    left_cnt = off_nib;
                    ph = P_OFFSET;
                end
                return 0;
            end
            P_OFFSET:
            begin
                idx = (off_nib - left_cnt) & 7;
                off_acc = off_acc | (64'(it.rbyte) << (idx * 8));
                left_cnt--;
                if (left_cnt == 0)
                    return close_run(r);
                return 0;
            end
            default: return 0;
        endcase
    endfunction

    // clock and reset
    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
    end

    // driver: presents queued items, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        loc_result_t r;
        if (!rst_n)
        begin
            s_tvalid <= 0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                items_sent++;
                if (items_sent > 590)
                    quiet = 1;
                if (predict_item(cur_item, r))
                    expected_q.insert(expected_q.size(), r);
                if (!quiet && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 8);
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 0;
                end
                else if (pending_q.size() > 0)
                begin
                    cur_item = pending_q.pop_front();
                    s_tvalid <= 1;
                    s_tdata  <= {cur_item.rec, cur_item.rbyte};
                    s_tuser  <= {cur_item.first, cur_item.cmd};
                end
                else
                    s_tvalid <= 0;
            end
        end
    end

    // monitor: checks results, random receive stalls
    always @(posedge clk or negedge rst_n)
    begin
        loc_result_t e;
        if (!rst_n)
            m_tready <= 0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result %h", m_tdata);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (m_tdata[2:0] !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[9:3] !== e.runs)
                    begin
                        $error("run_count exp %0d got %0d", e.runs, m_tdata[9:3]);
                        errors++;
                    end
                    if (m_tdata[72:10] !== e.cl)
                    begin
                        $error("cluster exp %h got %h", e.cl, m_tdata[72:10]);
                        errors++;
                    end
                    if (m_tdata[93:73] !== e.off)
                    begin
                        $error("offset_in_cluster exp %h got %h", e.off, m_tdata[93:73]);
                        errors++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                recv_stall = $urandom_range(0, 7);
                m_tready <= 0;
            end
            else
                m_tready <= 1;
        end
    end

    // run-time limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 2000000)
        begin
            $display("data_run_decode_and_locate_top regression: fail");
            $finish;
        end
    end

    task automatic push_byte(bit first, logic [7:0] b);
        run_item_t it;
        it.cmd = 0;
        it.first = first;
        it.rbyte = b;
        it.rec = 48'($urandom) ^ (48'($urandom) << 32);
        pending_q.insert(pending_q.size(), it);
        items_added++;
    endtask

    task automatic push_locate(logic [47:0] rec);
        run_item_t it;
        it.cmd = 1;
        it.first = 1'($urandom_range(0, 1));
        it.rbyte = 8'($urandom);
        it.rec = rec;
        pending_q.insert(pending_q.size(), it);
        items_added++;
    endtask

    // everything sent, every result back, plus time for trailing work
    task automatic wait_idle();
        while (pending_q.size() > 0 || s_tvalid || expected_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 0;
        cfg_writes++;
        case (idx)
            CFG_BPS: m_bps = val[12:0];
            CFG_SPC: m_spc = val[7:0];
            CFG_BPR: m_bpr = val[16:0];
            CFG_TSC: m_tsc = val[47:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(logic [12:0] bps, logic [7:0] spc, logic [16:0] bpr,
                                logic [47:0] tsc);
        write_reg(CFG_BPS, 64'(bps));
        write_reg(CFG_SPC, 64'(spc));
        write_reg(CFG_BPR, 64'(bpr));
        write_reg(CFG_TSC, 64'(tsc));
    endtask

    // one run: header, length bytes, offset bytes
    task automatic push_run(bit first, int ln, int on, bit nonzero);
        logic [7:0] b;
        push_byte(first, {4'(on), 4'(ln)});
        for (int i = 0; i < ln; i++)
            push_byte(0, (ln > 2 && i > 0) ? 8'($urandom_range(0, 1)) : 8'($urandom));
        for (int i = 0; i < on; i++)
        begin
            b = 8'($urandom);
            if (nonzero && i == 0 && b == 0)
                b = 8'h01;
            push_byte(0, b);
        end
    endtask

    task automatic push_list(int nruns);
        for (int i = 0; i < nruns; i++)
            push_run(i == 0, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8)
                     : $urandom_range(1, 2), $urandom_range(0, 8), 0);
        push_byte(nruns == 0, 8'h00);
    endtask

    task automatic push_locates(int n);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 3))
                0: push_locate(48'($urandom) ^ (48'($urandom) << 24));
                1: push_locate(48'($urandom_range(0, 63)));
                default: push_locate(48'($urandom_range(0, 8191)));
            endcase
    endtask

    initial
    begin
        int sel;
        cfg_valid = 0;
        cfg_index = CFG_BPS;
        cfg_data = '0;
        m_bps = 13'd512;
        m_spc = 8'd8;
        m_bpr = 17'd1024;
        m_tsc = '0;
        clear_runs();
        @(posedge rst_n);
        repeat (3) @(posedge clk);

        // directed: linear locate, a small list, end/bad headers, stop
        push_locate(48'd0);
        push_locate(48'hFFFF_FFFF_FFFF);
        push_byte(1, 8'h21); push_byte(0, 8'h10); push_byte(0, 8'h00); push_byte(0, 8'h01);
        push_byte(0, 8'h01); push_byte(0, 8'h05);               // run with no offset
        push_byte(0, 8'h11); push_byte(0, 8'h08); push_byte(0, 8'hFF); // negative offset
        push_byte(0, 8'h00);
        push_byte(0, 8'h33);                                    // ignored after stop
        push_locate(48'd0);
        push_locate(48'd100);
        push_locate(48'd4000);                                  // past all runs
        push_byte(1, 8'h00);                                    // empty list
        push_byte(1, 8'h09);                                    // length nibble too big
        push_byte(1, 8'h91);                                    // offset nibble too big
        push_byte(1, 8'h10);                                    // zero length nibble
        push_locate(48'd7);
        wait_idle();

        // extreme geometries
        set_geometry(13'd4096, 8'd255, 17'd1, 48'hFFFF_FFFF_FFFF);
        push_locate(48'hFFFF_FFFF_FFFF);
        push_locate(48'd1044479);
        wait_idle();
        set_geometry(13'd1, 8'd1, 17'd65536, 48'd0);
        push_locate(48'd5);
        wait_idle();
        write_reg(CFG_BPR, 64'd0);
        push_locate(48'd5);
        wait_idle();
        set_geometry(13'd512, 8'd0, 17'd512, 48'd1);
        push_locate(48'd5);
        wait_idle();
        set_geometry(13'd512, 8'd8, 17'd1024, 48'd0);

        // table overflow once
        for (int i = 0; i < 66; i++)
            push_run(i == 0, 1, 1, 1);
        push_byte(0, 8'h00);
        push_locates(4);
        wait_idle();

        // random phases
        while (items_added < 650)
        begin
            for (int k = 0; k < 12 && items_added < 650; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 45)
                begin
                    push_list($urandom_range(1, 8));
                    push_locates($urandom_range(3, 8));
                end
                else if (sel < 55)
                    push_locates(2);
                else if (sel < 65)
                begin
                    push_run(1, $urandom_range(1, 2), $urandom_range(0, 8), 0);
                    push_byte(0, 8'($urandom));
                    push_locates(2);
                end
                else if (sel < 75)
                    for (int j = 0; j < 4; j++)
                        push_byte(1'($urandom_range(0, 1)), 8'($urandom));
                else
                    push_list(0);
            end
            wait_idle();
            case ($urandom_range(0, 3))
                0: set_geometry(13'd512, 8'd8, 17'd1024, 48'($urandom));
                1: set_geometry(13'($urandom_range(1, 4096)), 8'($urandom_range(1, 255)),
                                17'($urandom_range(1, 4096)), 48'($urandom));
                2: set_geometry(13'($urandom), 8'($urandom), 17'($urandom),
                                {16'($urandom), 32'($urandom)});
                default: set_geometry(13'd4096, 8'd1, 17'd256, 48'd0);
            endcase
        end

        wait_idle();
        $display("Covered %0d items, %0d results, %0d register writes;", items_added,
                 results_seen, cfg_writes);
        $display("run lists with end, bad header and overflow, linear and walked locates.");
        if (errors == 0 && expected_q.size() == 0)
            $display("data_run_decode_and_locate_top regression: pass");
        else
            $display("data_run_decode_and_locate_top regression: fail");
        $finish;
    end
endmodule
